// File: sv/hcl_pkg.sv
// Shared constants, types and register codes for the HSV colour likelihood block.
`timescale 1ns / 1ps
package hcl_pkg;

    localparam int EVIDENCE_BITS = 16;
    localparam int DIFF_LIMIT    = 32;
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 16;
    localparam int APB_W         = 32;

    // Distance cap and width of a distance value (Q.16)
    localparam int D_CAP = (DIFF_LIMIT << 16) + 1;
    localparam int D_W   = $clog2(D_CAP + 1);
    localparam int Y_W   = D_W + 9;

    localparam int TAYLOR_TERMS = 8;
    localparam int SQUARINGS    = 6;

    // Pipeline depths
    localparam int ZSQ_LAT  = D_W + 4;
    localparam int NEXP_LAT = 3 * TAYLOR_TERMS + SQUARINGS + 2;
    localparam int PIPE_LAT = ZSQ_LAT + NEXP_LAT + 3;
    localparam int SUM_IDX  = ZSQ_LAT + 1;

    // Configuration register map
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_MEAN_HUE = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MEAN_SAT = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_MEAN_VAL = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_DEV_HUE  = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_DEV_SAT  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_DEV_VAL  = REG_IDX_W'(5);

    localparam logic [CFG_W-1:0] MEAN_RESET = '0;
    localparam logic [CFG_W-1:0] DEV_RESET  = CFG_W'(256);

    typedef logic [D_W-1:0] dist_t;

    localparam dist_t D_CAP_V   = D_W'(D_CAP);
    localparam dist_t D_LIMIT_V = D_W'(DIFF_LIMIT << 16);

    // Per-item flags that travel alongside the datapath
    typedef struct packed {
        logic vld;
        logic blk;
        logic dzero;
        logic dbig;
    } flag_t;

endpackage

// File: sv/hcl_zsq.sv
// One channel lane: difference to the mean, squares, and a pipelined divide to a z-score squared.
`timescale 1ns / 1ps
module hcl_zsq import hcl_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic             circ,
    input  logic [PIX_W-1:0] pix,
    input  logic [CFG_W-1:0] mean,
    input  logic [CFG_W-1:0] dev,
    output dist_t            term
);

    localparam int QS = D_W - 16;

    logic signed [17:0] diff;
    logic signed [17:0] diff_w;
    logic signed [17:0] mag_full;
    logic [15:0]        mag_reg;
    logic [15:0]        dv_reg;
    logic [31:0]        num_reg;
    logic [31:0]        den_reg;
    logic               ovf;

    logic [31:0]    rem_reg [0:D_W];
    logic [D_W-1:0] q_reg   [0:D_W];
    logic [D_W-1:0] nb_reg  [0:D_W];
    logic [31:0]    dd_reg  [0:D_W];
    logic           ov_reg  [0:D_W];
    dist_t          term_reg;

    // Signed Q8.8 difference, hue wrapped onto the circle
    always_comb begin
        diff   = $signed({2'b00, mean}) - $signed({2'b00, pix, 8'b0});
        diff_w = diff;
        if (circ && (diff < -18'sd32768)) begin
            diff_w = diff + 18'sd65280;
        end else if (circ && (diff > 18'sd32768)) begin
            diff_w = diff - 18'sd65280;
        end
        mag_full = (diff_w < 18'sd0) ? -diff_w : diff_w;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_full[15:0];
            dv_reg  <= (dev == '0) ? 16'd1 : dev;
            num_reg <= 32'(mag_reg) * 32'(mag_reg);
            den_reg <= 32'(dv_reg) * 32'(dv_reg);
        end
    end

    assign ovf = (num_reg >> QS) >= den_reg;

    // Division set-up: quotient overflow check and first partial remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            ov_reg[0]  <= ovf;
            rem_reg[0] <= ovf ? 32'd0 : (num_reg >> QS);
            q_reg[0]   <= '0;
            nb_reg[0]  <= {num_reg[QS-1:0], 16'b0};
            dd_reg[0]  <= den_reg;
        end
    end

    // One quotient bit per stage
    for (genvar g = 0; g < D_W; g++) begin : g_div
        logic [32:0] rs;
        logic        ge;
        always_comb begin
            rs = {rem_reg[g], nb_reg[g][D_W-1-g]};
            ge = rs >= {1'b0, dd_reg[g]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g+1] <= ge ? 32'(rs - {1'b0, dd_reg[g]}) : rs[31:0];
                q_reg[g+1]   <= {q_reg[g][D_W-2:0], ge};
                nb_reg[g+1]  <= nb_reg[g];
                dd_reg[g+1]  <= dd_reg[g];
                ov_reg[g+1]  <= ov_reg[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ov_reg[D_W] || (q_reg[D_W] > D_CAP_V)) begin
                term_reg <= D_CAP_V;
            end else begin
                term_reg <= q_reg[D_W];
            end
        end
    end

    assign term = term_reg;

endmodule

// File: sv/hcl_nexp.sv
// Pipelined exp(-d/2): Taylor series on d/128, six squarings, rounding to the output width.
`timescale 1ns / 1ps
module hcl_nexp import hcl_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  dist_t                    d,
    output logic [EVIDENCE_BITS-1:0] ev
);

    typedef struct packed {
        logic [Y_W-1:0] y;
        logic [32:0]    t;
        logic [33:0]    pos;
        logic [33:0]    neg;
        logic [Y_W-1:0] x;
        logic [Y_W-1:0] q0;
    } tay_t;

    tay_t        cin    [0:TAYLOR_TERMS];
    tay_t        st_reg [0:3*TAYLOR_TERMS-1];
    logic [31:0] rq_reg [0:SQUARINGS];
    logic [EVIDENCE_BITS-1:0] ev_reg;
    logic [32:0] rnd;
    logic [EVIDENCE_BITS:0]   rsh;

    always_comb begin
        cin[0]     = '0;
        cin[0].y   = {d, 9'b0};
        cin[0].t   = 33'h1_0000_0000;
        cin[0].pos = 34'h1_0000_0000;
    end

    for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / k);
        localparam int          KK    = k;
        logic [63:0]      prod_a;
        logic [64:0]      prod_b;
        logic [Y_W+3:0]   qk;
        logic [Y_W+3:0]   rr;
        logic [Y_W-1:0]   q;
        tay_t             mul_st;
        tay_t             est_st;
        tay_t             nxt;

        assign prod_a = 64'(cin[k-1].t) * 64'(cin[k-1].y);

        // Multiply by the term's running power of y
        always_comb begin
            mul_st   = cin[k-1];
            mul_st.x = prod_a[32 +: Y_W];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[3*k-3] <= mul_st;
            end
        end

        // Reciprocal estimate of x/k, low by at most one
        assign prod_b = 65'(st_reg[3*k-3].x) * 65'(RECIP);

        always_comb begin
            est_st    = st_reg[3*k-3];
            est_st.q0 = prod_b[32 +: Y_W];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[3*k-2] <= est_st;
            end
        end

        // Correct the estimate and accumulate the signed term
        always_comb begin
            qk  = (Y_W+4)'(st_reg[3*k-2].q0) * (Y_W+4)'(KK);
            rr  = (Y_W+4)'(st_reg[3*k-2].x) - qk;
            q   = (rr >= (Y_W+4)'(KK)) ? st_reg[3*k-2].q0 + 1'b1 : st_reg[3*k-2].q0;
            nxt   = st_reg[3*k-2];
            nxt.t = 33'(q);
            if ((k % 2) == 1) begin
                nxt.neg = st_reg[3*k-2].neg + 34'(q);
            end else begin
                nxt.pos = st_reg[3*k-2].pos + 34'(q);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[3*k-1] <= nxt;
            end
        end

        assign cin[k] = st_reg[3*k-1];
    end

    // Difference of the series halves, capped to 32 bits
    always_ff @(posedge aclk) begin
        if (en) begin
            if (cin[TAYLOR_TERMS].pos <= cin[TAYLOR_TERMS].neg) begin
                rq_reg[0] <= '0;
            end else if ((cin[TAYLOR_TERMS].pos - cin[TAYLOR_TERMS].neg) > 34'hFFFF_FFFF) begin
                rq_reg[0] <= 32'hFFFF_FFFF;
            end else begin
                rq_reg[0] <= 32'(cin[TAYLOR_TERMS].pos - cin[TAYLOR_TERMS].neg);
            end
        end
    end

    for (genvar i = 0; i < SQUARINGS; i++) begin : g_sq
        logic [63:0] sq;
        assign sq = 64'(rq_reg[i]) * 64'(rq_reg[i]);
        always_ff @(posedge aclk) begin
            if (en) begin
                rq_reg[i+1] <= sq[63:32];
            end
        end
    end

    always_comb begin
        rnd = 33'(rq_reg[SQUARINGS]) + (33'd1 << (31 - EVIDENCE_BITS));
        rsh = rnd[32 -: (EVIDENCE_BITS + 1)];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ev_reg <= rsh[EVIDENCE_BITS] ? '1 : rsh[EVIDENCE_BITS-1:0];
        end
    end

    assign ev = ev_reg;

endmodule

// File: sv/hsv_color_likelihood_top.sv
// Top level of the HSV colour likelihood block: register file, lanes, sum and output stage.
`timescale 1ns / 1ps
// Takes one HSV pixel per item and returns exp(-d/2) as unsigned Q0.16 evidence, where d
// sums the squared z-scores of hue, saturation and value against the programmed means and
// deviations (all Q8.8). Hue wraps around the colour circle; a black pixel (all bytes zero)
// gives 0, a zero distance gives all ones, and any distance above 32 gives 0. Throughput is
// one item per clock; the path from acceptance to m_valid runs through the
// one-bit-per-stage divider in each channel lane and the exponential pipeline
// (three stages per Taylor term, then six squarings). The whole pipeline advances together:
// it holds while a result waits at m_valid and m_ready is low, and s_ready drops then.
// Program the registers over APB only while no item is in flight; reads return the value.
module hsv_color_likelihood_top import hcl_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIX_W-1:0]         s_pix_hue,
    input  logic [PIX_W-1:0]         s_pix_sat,
    input  logic [PIX_W-1:0]         s_pix_val,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [EVIDENCE_BITS-1:0] m_evidence,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [APB_W-1:0]         pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     pready
);

    logic [CFG_W-1:0] mean_hue_reg, mean_sat_reg, mean_val_reg;
    logic [CFG_W-1:0] dev_hue_reg, dev_sat_reg, dev_val_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    logic en;
    logic [PIX_W-1:0] hue_reg, sat_reg, val_reg;
    flag_t flg_reg [0:PIPE_LAT-1];
    flag_t flg_next [0:PIPE_LAT-1];

    dist_t term_h, term_s, term_v;
    logic [D_W+1:0] sum3;
    dist_t d_reg;
    logic [EVIDENCE_BITS-1:0] ev_exp;
    logic [EVIDENCE_BITS-1:0] m_evidence_reg;
    logic [EVIDENCE_BITS-1:0] m_evidence_next;

    // Register file: write on the APB access phase
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_hue_reg <= MEAN_RESET;
            mean_sat_reg <= MEAN_RESET;
            mean_val_reg <= MEAN_RESET;
            dev_hue_reg  <= DEV_RESET;
            dev_sat_reg  <= DEV_RESET;
            dev_val_reg  <= DEV_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MEAN_HUE: mean_hue_reg <= pwdata[CFG_W-1:0];
                REG_MEAN_SAT: mean_sat_reg <= pwdata[CFG_W-1:0];
                REG_MEAN_VAL: mean_val_reg <= pwdata[CFG_W-1:0];
                REG_DEV_HUE:  dev_hue_reg  <= pwdata[CFG_W-1:0];
                REG_DEV_SAT:  dev_sat_reg  <= pwdata[CFG_W-1:0];
                REG_DEV_VAL:  dev_val_reg  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MEAN_HUE: prdata = APB_W'(mean_hue_reg);
            REG_MEAN_SAT: prdata = APB_W'(mean_sat_reg);
            REG_MEAN_VAL: prdata = APB_W'(mean_val_reg);
            REG_DEV_HUE:  prdata = APB_W'(dev_hue_reg);
            REG_DEV_SAT:  prdata = APB_W'(dev_sat_reg);
            REG_DEV_VAL:  prdata = APB_W'(dev_val_reg);
            default:      prdata = '0;
        endcase
    end

    // Global advance: move everything when the output register is free or being taken
    assign m_valid = flg_reg[PIPE_LAT-1].vld;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Capture the pixel
    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg <= s_pix_hue;
            sat_reg <= s_pix_sat;
            val_reg <= s_pix_val;
        end
    end

    // Three channel lanes in parallel; only hue wraps
    hcl_zsq u_zsq_hue (
        .aclk (aclk), .en (en), .circ (1'b1),
        .pix (hue_reg), .mean (mean_hue_reg), .dev (dev_hue_reg), .term (term_h)
    );
    hcl_zsq u_zsq_sat (
        .aclk (aclk), .en (en), .circ (1'b0),
        .pix (sat_reg), .mean (mean_sat_reg), .dev (dev_sat_reg), .term (term_s)
    );
    hcl_zsq u_zsq_val (
        .aclk (aclk), .en (en), .circ (1'b0),
        .pix (val_reg), .mean (mean_val_reg), .dev (dev_val_reg), .term (term_v)
    );

    // Saturating sum of the three terms
    assign sum3 = (D_W+2)'(term_h) + (D_W+2)'(term_s) + (D_W+2)'(term_v);

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= (sum3 > (D_W+2)'(D_CAP_V)) ? D_CAP_V : sum3[D_W-1:0];
        end
    end

    hcl_nexp u_nexp (
        .aclk (aclk), .en (en), .d (d_reg), .ev (ev_exp)
    );

    // Flags follow the item down the pipe; distance flags join at the sum stage
    always_comb begin
        flg_next[0].vld   = s_valid;
        flg_next[0].blk   = (s_pix_hue == '0) && (s_pix_sat == '0) && (s_pix_val == '0);
        flg_next[0].dzero = 1'b0;
        flg_next[0].dbig  = 1'b0;
        for (int i = 1; i < PIPE_LAT; i++) begin
            flg_next[i] = flg_reg[i-1];
            if (i == SUM_IDX) begin
                flg_next[i].dzero = (sum3 == '0);
                flg_next[i].dbig  = (sum3 > (D_W+2)'(D_LIMIT_V));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                flg_reg[i] <= '0;
            end
        end else if (en) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                flg_reg[i] <= flg_next[i];
            end
        end
    end

    // Output stage: apply the special cases
    always_comb begin
        if (flg_reg[PIPE_LAT-2].blk || flg_reg[PIPE_LAT-2].dbig) begin
            m_evidence_next = '0;
        end else if (flg_reg[PIPE_LAT-2].dzero) begin
            m_evidence_next = '1;
        end else begin
            m_evidence_next = ev_exp;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_evidence_reg <= m_evidence_next;
        end
    end

    assign m_evidence = m_evidence_reg;

endmodule

// File: sv/hcl_chk.sv
// Port-level checker for the HSV colour likelihood block, bound to the top level.
`timescale 1ns / 1ps
module hcl_chk import hcl_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [EVIDENCE_BITS-1:0] m_evidence,
    input logic                     pready
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_evidence))
        else $error("result changed while stalled");

    // Reset leaves no result pending
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Backpressure reaches the input side
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // Free output register always takes a new item
    a_free_in: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready && pready)
        else $error("input refused with empty output");

endmodule

bind hsv_color_likelihood_top hcl_chk u_hcl_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_evidence (m_evidence),
    .pready     (pready)
);

// File: test/hsv_color_likelihood_top_tb.sv
// Self-checking testbench for the HSV colour likelihood block.
`timescale 1ns / 1ps
module hsv_color_likelihood_top_tb;
    import hcl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = PIPE_LAT + 20;

    typedef struct {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] sat;
        logic [PIX_W-1:0] val;
    } pixel_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [PIX_W-1:0]         s_pix_hue = '0;
    logic [PIX_W-1:0]         s_pix_sat = '0;
    logic [PIX_W-1:0]         s_pix_val = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [EVIDENCE_BITS-1:0] m_evidence;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [APB_W-1:0]         pwdata = '0;
    logic [APB_W-1:0]         prdata;
    logic                     pready;

    // Testbench copy of the register file and the traffic stores
    logic [CFG_W-1:0]         cfg_shadow [NUM_REGS];
    pixel_t                   pixel_q [$];
    logic [EVIDENCE_BITS-1:0] evidence_q [$];

    int  cycle_cnt = 0;
    int  err_cnt = 0;
    int  items_in = 0;
    int  results_out = 0;
    int  nonzero_cnt = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_cnt = 0;
    bit  hold_req = 1'b0;
    bit  quiet = 1'b0;
    bit  s_took = 1'b0;

    hsv_color_likelihood_top i_dut (.*);

    always #6 aclk = ~aclk;

    // Squared z-score of one channel in Q.16, capped at D_CAP, just above the distance limit
    function automatic longint unsigned chan_score(longint signed diff, logic [CFG_W-1:0] dev);
        longint unsigned mag;
        longint unsigned dv;
        longint unsigned t;
        mag = (diff < 0) ? longint'(-diff) : longint'(diff);
        dv  = (dev == 0) ? 64'd1 : 64'(dev);
        t   = ((mag * mag) << 16) / (dv * dv);
        return (t > 64'(D_CAP)) ? 64'(D_CAP) : t;
    endfunction

    // Expected evidence for one pixel under the current register values
    function automatic logic [EVIDENCE_BITS-1:0] evidence_for(pixel_t p);
        longint signed   dh, ds, dv;
        longint unsigned dsum, y, pos, neg, t, r;
        if (p.hue == 0 && p.sat == 0 && p.val == 0)
            return '0;
        dh = longint'(cfg_shadow[REG_MEAN_HUE]) - (longint'(p.hue) << 8);
        if (dh < -32768)
            dh += 65280;
        if (dh > 32768)
            dh -= 65280;
        ds = longint'(cfg_shadow[REG_MEAN_SAT]) - (longint'(p.sat) << 8);
        dv = longint'(cfg_shadow[REG_MEAN_VAL]) - (longint'(p.val) << 8);
        dsum = chan_score(dh, cfg_shadow[REG_DEV_HUE]);
        dsum += chan_score(ds, cfg_shadow[REG_DEV_SAT]);
        if (dsum > 64'(D_CAP)) dsum = 64'(D_CAP);
        dsum += chan_score(dv, cfg_shadow[REG_DEV_VAL]);
        if (dsum > 64'(D_CAP)) dsum = 64'(D_CAP);
        if (dsum > (64'(DIFF_LIMIT) << 16))
            return '0;
        if (dsum == 0)
            return '1;
        y = dsum << 9;
        pos = 64'd1 << 32;
        neg = 64'd0;
        t = 64'd1 << 32;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            t = ((t * y) >> 32) / 64'(k);
            if (k % 2 == 1)
                neg += t;
            else
                pos += t;
        end
        r = (pos > neg) ? pos - neg : 64'd0;
        for (int i = 0; i < SQUARINGS; i++) begin
            if (r > 64'hFFFF_FFFF)
                r = 64'hFFFF_FFFF;
            r = (r * r) >> 32;
        end
        r = (r + (64'd1 << (31 - EVIDENCE_BITS))) >> (32 - EVIDENCE_BITS);
        if (r > ((64'd1 << EVIDENCE_BITS) - 1))
            r = (64'd1 << EVIDENCE_BITS) - 1;
        return EVIDENCE_BITS'(r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // Register write: setup cycle, then access cycle; update the copy on the write edge
    task automatic reg_write(int idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= APB_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx < NUM_REGS)
            cfg_shadow[idx] = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_check(int idx);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= ADDR_W'(idx * 4);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[CFG_W-1:0] !== cfg_shadow[idx])
            report_mismatch("register readback", longint'(prdata), longint'(cfg_shadow[idx]));
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_all(logic [CFG_W-1:0] mh, logic [CFG_W-1:0] ms,
                               logic [CFG_W-1:0] mv, logic [CFG_W-1:0] dh,
                               logic [CFG_W-1:0] ds, logic [CFG_W-1:0] dv);
        reg_write(int'(REG_MEAN_HUE), mh);
        reg_write(int'(REG_MEAN_SAT), ms);
        reg_write(int'(REG_MEAN_VAL), mv);
        reg_write(int'(REG_DEV_HUE), dh);
        reg_write(int'(REG_DEV_SAT), ds);
        reg_write(int'(REG_DEV_VAL), dv);
        for (int i = 0; i < NUM_REGS; i++)
            reg_check(i);
    endtask

    // Hold until every queued item is accepted and every result has come back
    task automatic drain();
        while (pixel_q.size() != 0 || s_valid || evidence_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic queue_pixel(int h, int s, int v);
        pixel_t p;
        p.hue = PIX_W'(h);
        p.sat = PIX_W'(s);
        p.val = PIX_W'(v);
        pixel_q.push_back(p);
    endtask

    // Byte near a Q8.8 mean, so that most random items land inside the distance limit
    function automatic int near_byte(logic [CFG_W-1:0] mean);
        int c;
        c = int'(mean >> 8) + int'($urandom_range(0, 8)) - 4;
        return (c < 0) ? 0 : (c > 255) ? 255 : c;
    endfunction

    task automatic random_items(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 7)
                queue_pixel(near_byte(cfg_shadow[REG_MEAN_HUE]), near_byte(cfg_shadow[REG_MEAN_SAT]),
                            near_byte(cfg_shadow[REG_MEAN_VAL]));
            else
                queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
        end
    endtask

    // Driver: advance to the next item once the current one is taken; idle in bursts
    always @(negedge aclk) begin
        pixel_t p;
        if (aresetn && (!s_valid || s_took)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 5);
                s_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                p = pixel_q.pop_front();
                s_valid <= 1'b1;
                s_pix_hue <= p.hue;
                s_pix_sat <= p.sat;
                s_pix_val <= p.val;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: a long hold-off on request, otherwise short random stalls
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 300;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted item, check every accepted result
    always @(posedge aclk) begin
        pixel_t p;
        logic [EVIDENCE_BITS-1:0] want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TB_ERROR");
            $finish;
        end else begin
            s_took = aresetn && s_valid && s_ready;
            if (s_took) begin
                p.hue = s_pix_hue;
                p.sat = s_pix_sat;
                p.val = s_pix_val;
                evidence_q.push_back(evidence_for(p));
                items_in++;
            end
            if (aresetn && m_valid && m_ready) begin
                results_out++;
                if (evidence_q.size() == 0) begin
                    report_mismatch("unexpected result", longint'(m_evidence), 64'd0);
                end else begin
                    want = evidence_q.pop_front();
                    if (want != 0)
                        nonzero_cnt++;
                    if (m_evidence !== want)
                        report_mismatch("evidence", longint'(m_evidence), longint'(want));
                end
            end
        end
    end

    initial begin
        cfg_shadow[REG_MEAN_HUE] = MEAN_RESET;
        cfg_shadow[REG_MEAN_SAT] = MEAN_RESET;
        cfg_shadow[REG_MEAN_VAL] = MEAN_RESET;
        cfg_shadow[REG_DEV_HUE]  = DEV_RESET;
        cfg_shadow[REG_DEV_SAT]  = DEV_RESET;
        cfg_shadow[REG_DEV_VAL]  = DEV_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values: black pixel, field extremes, single-bit steps
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(0, 0, 1);
        queue_pixel(1, 0, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(170, 85, 0);
        drain();

        // Mid-range target: zero distance, hue wrap, distance beyond the limit
        program_all(16'h8000, 16'h4000, 16'h2000, 16'h0800, 16'h0800, 16'h0800);
        queue_pixel(128, 64, 32);
        queue_pixel(0, 64, 32);
        queue_pixel(255, 64, 32);
        queue_pixel(129, 65, 33);
        queue_pixel(132, 60, 36);
        queue_pixel(0, 0, 0);
        queue_pixel(128, 255, 32);
        drain();
        reg_write(int'(REG_MEAN_HUE), 16'h0000);
        queue_pixel(200, 64, 32);
        queue_pixel(100, 64, 32);
        queue_pixel(129, 64, 32);
        queue_pixel(127, 64, 32);
        drain();

        // A deviation of zero acts as the smallest step; an unknown index is dropped
        program_all(16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
        reg_write(NUM_REGS, 16'hFFFF);
        queue_pixel(1, 1, 1);
        queue_pixel(1, 1, 2);
        queue_pixel(2, 1, 1);
        drain();

        // Random phases; both extremes of the register range come first
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: program_all(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001);
                default: program_all(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                     CFG_W'($urandom_range(128, 3000)),
                                     CFG_W'($urandom_range(128, 3000)),
                                     CFG_W'($urandom_range(128, 3000)));
            endcase
            // Stall the receiver for a long stretch while items keep coming
            if (ph == 3)
                hold_req = 1'b1;
            if (ph == 7)
                quiet = 1'b1;
            random_items(204);
            drain();
        end

        $display("items sent %0d, results checked %0d, nonzero evidence %0d",
                 items_in, results_out, nonzero_cnt);
        $display("covered black pixels, hue wrap, zero deviation, register extremes, stalls");
        if (err_cnt == 0 && evidence_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
